// ----- hdl/ffra_pkg.sv -----
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and constants
// Status codes, actions and the command and status structs for the allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int UNIT_SHIFT = 4;

  // Largest region in units; the entry and result widths are sized for it.
  localparam int REGION_UNITS = 4096;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOSPACE  = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_BADINDEX = 3'd5
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the request fields
    logic scan_clear;  // restart the scan at entry 0
    logic scan_step;   // advance the scan index
    logic set_start;   // candidate start := end of current entry
    logic shift;       // move one entry (down for alloc, up for free)
    logic shift_up;    // direction of shift: 1 = toward index 0
    logic write_new;   // write the new block at entry 0
    logic commit_alloc;
    logic commit_free;
    logic capture;     // register the result
    logic [2:0] status;
    logic with_block;  // result carries block fields
  } ffra_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;   // scan index reached live count
    logic overlap;     // current entry overlaps candidate
    logic match;       // current entry start equals offset
    logic fits;        // candidate fits in capacity
    logic full;        // table full
    logic empty;       // nothing allocated
    logic idx_ok;      // lookup index in range
    logic shift_done;  // shift pointer reached its end
  } ffra_stat_t;

endpackage

// ----- hdl/ffra_if.sv -----
// ----------------------------------------------------------------------------
// ffra_req_if / ffra_rsp_if: request and result channels
// Valid/ready channels carrying the allocator payload.
// ----------------------------------------------------------------------------
interface ffra_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [16:0] request_bytes;
  logic [15:0] free_offset;
  logic [4:0]  entry_index;
  modport source (output valid, action, request_bytes, free_offset, entry_index,
                  input ready);
  modport sink (input valid, action, request_bytes, free_offset, entry_index,
                output ready);
endinterface

interface ffra_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] block_offset;
  logic [16:0] block_bytes;
  logic [16:0] used_bytes;
  logic [5:0]  block_count;
  modport source (output valid, status, block_offset, block_bytes, used_bytes,
                  block_count, input ready);
  modport sink (input valid, status, block_offset, block_bytes, used_bytes,
                block_count, output ready);
endinterface

// ----- hdl/ffra_ram.sv -----
// ----------------------------------------------------------------------------
// ffra_ram: generic single-port write, single-port read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/ffra_datapath.sv -----
// ----------------------------------------------------------------------------
// ffra_datapath: entry table, scan registers and result register
// Holds the table RAM, live count, used units and the candidate start.
// ----------------------------------------------------------------------------
module ffra_datapath #(
  parameter int MAX_BLOCKS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [12:0]          cfg_wdata,
  input  logic [1:0]           in_action,
  input  logic [16:0]          in_request_bytes,
  input  logic [15:0]          in_free_offset,
  input  logic [4:0]           in_entry_index,
  input  ffra_pkg::ffra_cmd_t  cmd,
  output ffra_pkg::ffra_stat_t stat,
  output logic [2:0]           res_status,
  output logic [15:0]          res_offset,
  output logic [16:0]          res_bytes,
  output logic [16:0]          res_used,
  output logic [5:0]           res_count
);
  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = 25;  // 12-bit start, 13-bit size

  logic [12:0]   cap_r;
  logic [CW-1:0] live_r;
  logic [12:0]   used_r;
  logic [13:0]   n_r;
  logic [13:0]   s_r;
  logic [15:0]   off_r;
  logic [4:0]    idx_r;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [11:0]   e_start;
  logic [12:0]   e_size;
  logic [13:0]   e_end;
  logic [13:0]   cap_eff;

  assign e_start = rdata[EW-1:13];
  assign e_size  = rdata[12:0];
  assign e_end   = {2'b0, e_start} + {1'b0, e_size};
  assign cap_eff = ({1'b0, cap_r} > 14'(ffra_pkg::REGION_UNITS)) ?
                   14'(ffra_pkg::REGION_UNITS) : {1'b0, cap_r};

  // A shift toward the end of the table reads one entry below the pointer,
  // so the registered read holds the source entry when the write happens.
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.scan_clear) begin
      ptr_nxt = '0;
    end else if (cmd.scan_step) begin
      ptr_nxt = ptr_r + 1'b1;
    end else if (cmd.commit_alloc) begin
      ptr_nxt = live_r;
    end else if (cmd.shift) begin
      ptr_nxt = cmd.shift_up ? ptr_r + 1'b1 : ptr_r - 1'b1;
    end
    raddr = ptr_nxt[AW-1:0];
    if (cmd.commit_alloc || (cmd.shift && !cmd.shift_up)) begin
      raddr = AW'(ptr_nxt - 1'b1);
    end
    if (cmd.load && in_action == ffra_pkg::ACT_LOOKUP) begin
      raddr = AW'(in_entry_index);
    end
    we    = 1'b0;
    waddr = ptr_r[AW-1:0];
    wdata = rdata;
    if (cmd.shift) begin
      we    = 1'b1;
      waddr = cmd.shift_up ? AW'(ptr_r - 1'b1) : ptr_r[AW-1:0];
    end else if (cmd.write_new) begin
      we    = 1'b1;
      waddr = '0;
      wdata = {s_r[11:0], n_r[12:0]};
    end
  end

  ffra_ram #(.WIDTH(EW), .DEPTH(1 << AW)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    stat.scan_done  = (ptr_r >= live_r);
    stat.overlap    = (s_r < e_end) && ({2'b0, e_start} < s_r + n_r);
    stat.match      = ({e_start, 4'b0} == off_r);
    stat.fits       = (s_r + n_r <= cap_eff);
    stat.full       = (live_r >= CW'(MAX_BLOCKS));
    stat.empty      = (live_r == '0);
    stat.idx_ok     = ({1'b0, idx_r} < 6'(live_r)) && (32'(idx_r) < MAX_BLOCKS);
    stat.shift_done = cmd.shift_up ? (ptr_r > live_r) : (ptr_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= 13'd4096;
      live_r <= '0;
      used_r <= '0;
      ptr_r  <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      ptr_r <= ptr_nxt;
      if (cmd.commit_alloc) begin
        live_r <= live_r + 1'b1;
        used_r <= used_r + n_r[12:0];
      end
      if (cmd.commit_free) begin
        live_r <= live_r - 1'b1;
        used_r <= used_r - e_size;
      end
    end
    if (cmd.load) begin
      n_r   <= 14'((18'(in_request_bytes) + 18'd15) >> ffra_pkg::UNIT_SHIFT);
      s_r   <= '0;
      off_r <= in_free_offset;
      idx_r <= in_entry_index;
    end
    if (cmd.set_start) begin
      s_r <= e_end;
    end
    if (cmd.capture) begin
      res_status <= cmd.status;
      if (!cmd.with_block) begin
        res_offset <= '0;
        res_bytes  <= '0;
      end else if (cmd.commit_alloc) begin
        res_offset <= {s_r[11:0], 4'b0};
        res_bytes  <= {n_r[12:0], 4'b0};
      end else begin
        res_offset <= {e_start, 4'b0};
        res_bytes  <= {e_size, 4'b0};
      end
      if (cmd.commit_alloc) begin
        res_used  <= 17'({used_r + n_r[12:0], 4'b0});
        res_count <= 6'(live_r + 1'b1);
      end else if (cmd.commit_free) begin
        res_used  <= 17'({used_r - e_size, 4'b0});
        res_count <= 6'(live_r - 1'b1);
      end else begin
        res_used  <= 17'({used_r, 4'b0});
        res_count <= 6'(live_r);
      end
    end
  end
endmodule

// ----- hdl/ffra_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffra_ctrl: allocator sequencer
// Runs the scan, the table shift and the handshakes of both channels.
// ----------------------------------------------------------------------------
module ffra_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ffra_pkg::ffra_stat_t stat,
  output ffra_pkg::ffra_cmd_t  cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_CHECK, S_SHDN, S_FREAD, S_FSHUP, S_LOOK, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] act_r, act_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.status    = ffra_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          act_nxt    = in_action;
          cmd.scan_clear = 1'b1;
          case (ffra_pkg::action_t'(in_action))
            ffra_pkg::ACT_ALLOC:  state_nxt = S_SCAN;
            ffra_pkg::ACT_FREE:   state_nxt = S_SCAN;
            ffra_pkg::ACT_LOOKUP: state_nxt = S_LOOK;
            default: begin
              cmd.capture = 1'b1;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Read data for the pointed entry is valid in this state.
        if (act_r == ffra_pkg::ACT_ALLOC) begin
          if (stat.full) begin
            cmd.capture = 1'b1;
            cmd.status  = ffra_pkg::ST_FULL;
            state_nxt   = S_DONE;
          end else if (stat.scan_done) begin
            state_nxt = S_CHECK;
          end else if (stat.overlap) begin
            cmd.set_start  = 1'b1;
            cmd.scan_clear = 1'b1;
            state_nxt      = S_FREAD;
          end else begin
            cmd.scan_step = 1'b1;
            state_nxt     = S_FREAD;
          end
        end else begin
          if (stat.empty) begin
            cmd.capture = 1'b1;
            cmd.status  = ffra_pkg::ST_EMPTY;
            state_nxt   = S_DONE;
          end else if (stat.scan_done) begin
            cmd.capture = 1'b1;
            cmd.status  = ffra_pkg::ST_NOTFOUND;
            state_nxt   = S_DONE;
          end else if (stat.match) begin
            // Step the pointer to the entry after the match; it is the first
            // one to move up.
            cmd.capture     = 1'b1;
            cmd.commit_free = 1'b1;
            cmd.scan_step   = 1'b1;
            cmd.shift_up    = 1'b1;
            state_nxt       = S_FSHUP;
          end else begin
            cmd.scan_step = 1'b1;
            state_nxt     = S_FREAD;
          end
        end
      end
      S_FREAD: begin
        // Wait for the registered read.
        state_nxt = S_SCAN;
      end
      S_CHECK: begin
        if (!stat.fits) begin
          cmd.capture = 1'b1;
          cmd.status  = ffra_pkg::ST_NOSPACE;
          state_nxt   = S_DONE;
        end else begin
          // Pointer goes to live count; shift entries down from the top.
          cmd.commit_alloc = 1'b1;
          cmd.capture      = 1'b1;
          cmd.with_block   = 1'b1;
          cmd.status       = ffra_pkg::ST_OK;
          cmd.load         = 1'b0;
          state_nxt        = S_SHDN;
        end
      end
      S_SHDN: begin
        // Read data holds entry ptr-1; it moves to ptr. At entry 0 the new
        // block is written.
        if (stat.shift_done) begin
          cmd.write_new = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_LOOK: begin
        cmd.capture    = 1'b1;
        cmd.with_block = stat.idx_ok;
        cmd.status     = stat.idx_ok ? ffra_pkg::ST_OK : ffra_pkg::ST_BADINDEX;
        state_nxt      = S_DONE;
      end
      S_FSHUP: begin
        // Read data holds entry ptr; move it to ptr-1.
        cmd.shift_up = 1'b1;
        if (stat.shift_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// ----- hdl/first_fit_region_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_region_allocator: first-fit allocator over 16-byte units
// Allocate, free by offset and lookup by index over an ordered block table.
// ----------------------------------------------------------------------------
// One request is handled at a time. An ignored action has its result ready
// in the cycle after it is taken; a lookup passes through a lookup state and
// a done state first. An allocate scans the table through the single read
// port of the table RAM, visiting each entry in a scan state and a read-wait
// state, restarting from entry 0 each time the candidate start moves past an
// overlapping block, then shifts the table down by one entry per cycle and
// writes the new block at entry 0; the worst case grows with the square of
// the live count. A free scans up to the matched entry the same way and
// shifts the rest up one entry per cycle. The result waits in an output
// register until taken; no new request is taken while it waits.
module first_fit_region_allocator #(
  parameter int MAX_BLOCKS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  ffra_req_if.sink    in_req,
  ffra_rsp_if.source  out_rsp
);
  ffra_pkg::ffra_cmd_t  cmd;
  ffra_pkg::ffra_stat_t stat;

  ffra_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_req.valid), .in_ready(in_req.ready), .in_action(in_req.action),
    .out_valid(out_rsp.valid), .out_ready(out_rsp.ready),
    .stat(stat), .cmd(cmd)
  );

  ffra_datapath #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_action(in_req.action), .in_request_bytes(in_req.request_bytes),
    .in_free_offset(in_req.free_offset), .in_entry_index(in_req.entry_index),
    .cmd(cmd), .stat(stat),
    .res_status(out_rsp.status), .res_offset(out_rsp.block_offset),
    .res_bytes(out_rsp.block_bytes), .res_used(out_rsp.used_bytes),
    .res_count(out_rsp.block_count)
  );
endmodule
